FILE: rtl/touch_contact_stitcher_assert.svh
// Assertion macros shared by the touch contact stitcher RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef TOUCH_CONTACT_STITCHER_ASSERT_SVH
`define TOUCH_CONTACT_STITCHER_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TCS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("touch stitcher assertion failed");
`define TCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("touch stitcher sequence assertion failed");
`else
`define TCS_ASSERT(lbl, clk, rst_n, prop)
`define TCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/tcs_pkg.sv
// Shared constants, codes and controller/datapath structs for the stitcher.
// No dependencies.
`timescale 1ns / 1ps
package tcs_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned VAL_W  = 24;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned PEAK_W = 34;
  localparam int unsigned SSQ_W  = 48;
  localparam int unsigned NUM_W  = 36;
  localparam int unsigned US_W   = 22;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  localparam logic [2:0] ACT_STOP  = 3'd0;
  localparam logic [2:0] ACT_PAN   = 3'd1;
  localparam logic [2:0] ACT_TAP   = 3'd2;
  localparam logic [2:0] ACT_PRESS = 3'd3;
  localparam logic [2:0] ACT_FLING = 3'd4;

  localparam logic [IDX_W-1:0] REG_WINDOW = 3'd0;
  localparam logic [IDX_W-1:0] REG_RADIUS = 3'd1;
  localparam logic [IDX_W-1:0] REG_PRESS  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SLOP   = 3'd3;
  localparam logic [IDX_W-1:0] REG_FLING  = 3'd4;

  localparam logic [11:0] DEF_WINDOW = 12'd220;
  localparam logic [11:0] DEF_RADIUS = 12'd72;
  localparam logic [11:0] DEF_PRESS  = 12'd550;
  localparam logic [11:0] DEF_SLOP   = 12'd22;
  localparam logic [15:0] DEF_FLING  = 16'd120;

  localparam logic [1:0] SQ_SX = 2'd0;
  localparam logic [1:0] SQ_SY = 2'd1;
  localparam logic [1:0] SQ_DX = 2'd2;
  localparam logic [1:0] SQ_DY = 2'd3;

  localparam logic [TIME_W-1:0] MIN_DT_US = 32'd500;
  localparam logic [19:0]        US_PER_S  = 20'd1000000;

  typedef struct packed {
    logic       latch;
    logic       sq_en;
    logic [1:0] sq_sel;
    logic       eval;
    logic       num_en;
    logic       axis;
    logic       div_start;
    logic       blend_en;
    logic       out_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       need_div;
    logic [1:0] res_cnt;
    logic [1:0] eval_cnt;
    logic       div_done;
  } dp_stat_t;

endpackage

FILE: rtl/touch_contact_stitcher.sv
// Top level of the touch contact stitcher: controller plus datapath.
// Depends on tcs_pkg, tcs_ctrl, tcs_datapath (and tcs_div below it).
//
//  channel | signals                                      | dir
//  in      | in_valid_i/in_ready_o, operation, pos, now   | in
//  out     | out_valid_o/out_ready_i, action, value, last | out
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i              | in
//
// An item is squared and evaluated, then its result beats are sent; an update that samples
// velocity adds two passes of the bit-serial divider, one for each axis.
// One item is in flight at a time; in_ready_o is high only when idle.
// Reset restores the register defaults and clears all gesture state.
// A stalled output beat holds the block until it is taken.
`timescale 1ns / 1ps
module touch_contact_stitcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  operation_i,
  input  logic [tcs_pkg::POS_W-1:0]   pos_x_i,
  input  logic [tcs_pkg::POS_W-1:0]   pos_y_i,
  input  logic [tcs_pkg::TIME_W-1:0]  now_us_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  action_o,
  output logic signed [tcs_pkg::VAL_W-1:0] value_x_o,
  output logic signed [tcs_pkg::VAL_W-1:0] value_y_o,
  output logic                        last_o,
  input  logic                        cfg_we_i,
  input  logic [tcs_pkg::IDX_W-1:0]   cfg_idx_i,
  input  logic [tcs_pkg::CFG_W-1:0]   cfg_data_i
);
  import tcs_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .last_o      (last_o),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  tcs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .operation_i (operation_i),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .now_us_i    (now_us_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .action_o    (action_o),
    .value_x_o   (value_x_o),
    .value_y_o   (value_y_o)
  );

endmodule

FILE: rtl/tcs_div.sv
// Restoring divider, one quotient bit per cycle, for the velocity rate.
// Depends on tcs_pkg.
`timescale 1ns / 1ps
module tcs_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tcs_pkg::NUM_W-1:0]  num_i,
  input  logic [tcs_pkg::TIME_W-1:0] den_i,
  output logic                       done_o,
  output logic [tcs_pkg::NUM_W-1:0]  quo_o
);
  import tcs_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [TIME_W-1:0] rem_q, rem_d, den_q;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [TIME_W:0]   rem_sh;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
      done_d = 1'b0;
      rem_d  = '0;
      quo_d  = num_i;
    end else if (busy_q) begin
      rem_d = ge ? TIME_W'(rem_sh - {1'b0, den_q}) : rem_sh[TIME_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: rtl/tcs_datapath.sv
// Gesture state, config registers, shared squarer, rate divider and result buffer.
// Depends on tcs_pkg and tcs_div.
`timescale 1ns / 1ps
module tcs_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tcs_pkg::ctrl_cmd_t         cmd_i,
  output tcs_pkg::dp_stat_t          stat_o,
  input  logic [1:0]                 operation_i,
  input  logic [tcs_pkg::POS_W-1:0]  pos_x_i,
  input  logic [tcs_pkg::POS_W-1:0]  pos_y_i,
  input  logic [tcs_pkg::TIME_W-1:0] now_us_i,
  input  logic                       cfg_we_i,
  input  logic [tcs_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [tcs_pkg::CFG_W-1:0]  cfg_data_i,
  output logic [2:0]                 action_o,
  output logic signed [tcs_pkg::VAL_W-1:0] value_x_o,
  output logic signed [tcs_pkg::VAL_W-1:0] value_y_o
);
  import tcs_pkg::*;

  // configuration and derived thresholds
  logic [11:0] win_q, rad_q, lp_q, slop_q;
  logic [15:0] fling_q;
  logic [US_W-1:0] win_us_q, lp_us_q;
  logic [31:0] rad_sq_q, slop_sq_q;
  logic [39:0] fling_sq_q;
  logic [15:0] rad16, slop16;
  logic [19:0] fling16;

  assign rad16   = {rad_q, 4'd0};
  assign slop16  = {slop_q, 4'd0};
  assign fling16 = {fling_q, 4'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= DEF_WINDOW;
      rad_q   <= DEF_RADIUS;
      lp_q    <= DEF_PRESS;
      slop_q  <= DEF_SLOP;
      fling_q <= DEF_FLING;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WINDOW: win_q   <= cfg_data_i[11:0];
        REG_RADIUS: rad_q   <= cfg_data_i[11:0];
        REG_PRESS:  lp_q    <= cfg_data_i[11:0];
        REG_SLOP:   slop_q  <= cfg_data_i[11:0];
        REG_FLING:  fling_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    win_us_q   <= {10'd0, win_q} * 22'd1000;
    lp_us_q    <= {10'd0, lp_q} * 22'd1000;
    rad_sq_q   <= rad16 * rad16;
    slop_sq_q  <= slop16 * slop16;
    fling_sq_q <= fling16 * fling16;
  end

  // item and gesture state
  logic [1:0]        op_q;
  logic [POS_W-1:0]  x_q, y_q, rec_x_q, rec_y_q, org_x_q, org_y_q;
  logic [TIME_W-1:0] now_q, rec_t_q, smp_t_q, prs_t_q, stl_t_q, el_q;
  logic              seen_q, consumed_q, smp_v_q, prs_p_q, stl_p_q;
  logic [PEAK_W-1:0] peak_q;
  logic signed [VAL_W-1:0] spd_x_q, spd_y_q;
  logic signed [POS_W:0]   pan_dx_q, pan_dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q  <= operation_i;
      x_q   <= pos_x_i;
      y_q   <= pos_y_i;
      now_q <= now_us_i;
    end
  end

  // shared squarer
  logic [POS_W-1:0]        ref_x, ref_y;
  logic signed [24:0]      sq_opnd;
  logic signed [49:0]      sq_prod;
  logic [SSQ_W-1:0]        sxx_q, syy_q;
  logic [PEAK_W-1:0]       dxx_q, dyy_q;

  assign ref_x = (op_q == OP_BEGIN) ? rec_x_q : org_x_q;
  assign ref_y = (op_q == OP_BEGIN) ? rec_y_q : org_y_q;

  always_comb begin
    case (cmd_i.sq_sel)
      SQ_SX:   sq_opnd = 25'(spd_x_q);
      SQ_SY:   sq_opnd = 25'(spd_y_q);
      SQ_DX:   sq_opnd = 25'($signed({1'b0, x_q}) - $signed({1'b0, ref_x}));
      default: sq_opnd = 25'($signed({1'b0, y_q}) - $signed({1'b0, ref_y}));
    endcase
  end
  assign sq_prod = sq_opnd * sq_opnd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) begin
      case (cmd_i.sq_sel)
        SQ_SX:   sxx_q <= sq_prod[SSQ_W-1:0];
        SQ_SY:   syy_q <= sq_prod[SSQ_W-1:0];
        SQ_DX:   dxx_q <= sq_prod[PEAK_W-1:0];
        default: dyy_q <= sq_prod[PEAK_W-1:0];
      endcase
    end
  end

  // evaluation of timers and the item
  logic [PEAK_W-1:0] dist_sq, peak_new;
  logic [SSQ_W:0]    spd_sq;
  logic [TIME_W-1:0] el_now;
  logic prs_fire, p_emit, cons_mid, stl_fire, s_tap, s_fling, t_emit, o_emit;
  logic in_slop, same, upd_emit;
  logic [2:0] t_act, o_act;
  logic signed [VAL_W-1:0] t_vx, t_vy, o_vx, o_vy;
  logic signed [POS_W:0] dx_now, dy_now;

  assign dist_sq = dxx_q + dyy_q;
  assign spd_sq  = {1'b0, sxx_q} + {1'b0, syy_q};
  assign in_slop = peak_q <= PEAK_W'(slop_sq_q);
  assign el_now  = now_q - smp_t_q;
  assign dx_now  = $signed({1'b0, x_q}) - $signed({1'b0, rec_x_q});
  assign dy_now  = $signed({1'b0, y_q}) - $signed({1'b0, rec_y_q});

  assign prs_fire = prs_p_q && ((now_q - prs_t_q) >= TIME_W'(lp_us_q));
  assign p_emit   = prs_fire && in_slop;
  assign cons_mid = consumed_q || p_emit;
  assign stl_fire = stl_p_q && ((now_q - stl_t_q) >= TIME_W'(win_us_q));
  assign s_tap    = stl_fire && !cons_mid && in_slop;
  assign s_fling  = stl_fire && !cons_mid && !in_slop && (spd_sq > (SSQ_W+1)'(fling_sq_q));
  assign t_emit   = p_emit || s_tap || s_fling;

  assign same = seen_q && ((now_q - rec_t_q) < TIME_W'(win_us_q))
                && (dist_sq < PEAK_W'(rad_sq_q));
  assign peak_new = (dist_sq > peak_q) ? dist_sq : peak_q;
  assign upd_emit = peak_new > PEAK_W'(slop_sq_q);
  assign o_emit   = ((op_q == OP_BEGIN) && !same) || ((op_q == OP_UPDATE) && upd_emit);

  always_comb begin
    if (s_fling) begin
      t_act = ACT_FLING;
      t_vx  = spd_x_q;
      t_vy  = spd_y_q;
    end else begin
      t_act = p_emit ? ACT_PRESS : ACT_TAP;
      t_vx  = VAL_W'({1'b0, org_x_q});
      t_vy  = VAL_W'({1'b0, org_y_q});
    end
    if (op_q == OP_BEGIN) begin
      o_act = ACT_STOP;
      o_vx  = '0;
      o_vy  = '0;
    end else begin
      o_act = ACT_PAN;
      o_vx  = VAL_W'(dx_now);
      o_vy  = VAL_W'(dy_now);
    end
  end

  assign stat_o.need_div = (op_q == OP_UPDATE) && upd_emit && smp_v_q && (el_now > MIN_DT_US);
  assign stat_o.eval_cnt = {1'b0, t_emit} + {1'b0, o_emit};

  // velocity rate
  logic signed [POS_W:0] num_step;
  logic [POS_W-1:0]      num_mag;
  logic [NUM_W-1:0]      num_q, quo;
  logic                  neg_q, div_done;
  logic                  sat;
  logic signed [VAL_W-1:0] rate, spd_sel;
  logic signed [VAL_W:0]   bsum;

  assign num_step = cmd_i.axis ? pan_dy_q : pan_dx_q;
  assign num_mag  = num_step[POS_W] ? POS_W'(-num_step) : num_step[POS_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.num_en) begin
      num_q <= num_mag * US_PER_S;
      neg_q <= num_step[POS_W];
    end
  end

  tcs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_q),
    .den_i   (el_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );
  assign stat_o.div_done = div_done;

  always_comb begin
    if (neg_q) begin
      sat  = quo > NUM_W'(8388608);
      rate = sat ? $signed(24'h800000) : $signed(-quo[VAL_W-1:0]);
    end else begin
      sat  = quo > NUM_W'(8388607);
      rate = sat ? $signed(24'h7FFFFF) : $signed(quo[VAL_W-1:0]);
    end
  end
  assign spd_sel = cmd_i.axis ? spd_y_q : spd_x_q;
  assign bsum    = (VAL_W+1)'(spd_sel) + (VAL_W+1)'(rate);

  // state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      consumed_q <= 1'b0;
      smp_v_q    <= 1'b0;
      prs_p_q    <= 1'b0;
      stl_p_q    <= 1'b0;
      rec_x_q    <= '0;
      rec_y_q    <= '0;
      rec_t_q    <= '0;
      org_x_q    <= '0;
      org_y_q    <= '0;
      peak_q     <= '0;
      spd_x_q    <= '0;
      spd_y_q    <= '0;
      smp_t_q    <= '0;
      prs_t_q    <= '0;
      stl_t_q    <= '0;
    end else if (cmd_i.eval) begin
      prs_p_q    <= prs_p_q && !prs_fire;
      stl_p_q    <= stl_p_q && !stl_fire;
      consumed_q <= cons_mid && !stl_fire;
      case (op_q)
        OP_BEGIN: begin
          stl_p_q <= 1'b0;
          if (!same) begin
            org_x_q    <= x_q;
            org_y_q    <= y_q;
            peak_q     <= '0;
            consumed_q <= 1'b0;
            spd_x_q    <= '0;
            spd_y_q    <= '0;
            smp_v_q    <= 1'b0;
            prs_p_q    <= 1'b1;
            prs_t_q    <= now_q;
          end
        end
        OP_UPDATE: begin
          peak_q <= peak_new;
          if (upd_emit) begin
            prs_p_q <= 1'b0;
            smp_t_q <= now_q;
            smp_v_q <= 1'b1;
          end
        end
        OP_END: begin
          prs_p_q <= 1'b0;
          stl_p_q <= 1'b1;
          stl_t_q <= now_q;
        end
        default: ;
      endcase
      if (op_q != OP_TICK) begin
        rec_x_q <= x_q;
        rec_y_q <= y_q;
        rec_t_q <= now_q;
        seen_q  <= 1'b1;
      end
    end else if (cmd_i.blend_en) begin
      if (cmd_i.axis) spd_y_q <= bsum[VAL_W:1];
      else            spd_x_q <= bsum[VAL_W:1];
    end
  end

  // result buffer
  logic [2:0]              res_act_q [2];
  logic signed [VAL_W-1:0] res_x_q [2];
  logic signed [VAL_W-1:0] res_y_q [2];
  logic [1:0]              res_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_cnt_q <= '0;
    else if (cmd_i.eval) res_cnt_q <= stat_o.eval_cnt;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      pan_dx_q <= dx_now;
      pan_dy_q <= dy_now;
      el_q     <= el_now;
      if (t_emit) begin
        res_act_q[0] <= t_act;
        res_x_q[0]   <= t_vx;
        res_y_q[0]   <= t_vy;
        res_act_q[1] <= o_act;
        res_x_q[1]   <= o_vx;
        res_y_q[1]   <= o_vy;
      end else begin
        res_act_q[0] <= o_act;
        res_x_q[0]   <= o_vx;
        res_y_q[0]   <= o_vy;
      end
    end
  end

  assign stat_o.res_cnt = res_cnt_q;
  assign action_o  = res_act_q[cmd_i.out_idx];
  assign value_x_o = res_x_q[cmd_i.out_idx];
  assign value_y_o = res_y_q[cmd_i.out_idx];

endmodule

FILE: rtl/tcs_ctrl.sv
// Sequencer: squares, evaluation, velocity division per axis, result beats.
// Depends on tcs_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "touch_contact_stitcher_assert.svh"
module tcs_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               last_o,
  output tcs_pkg::ctrl_cmd_t cmd_o,
  input  tcs_pkg::dp_stat_t  stat_i
);
  import tcs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SQ    = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_NUM   = 3'd3;
  localparam logic [2:0] S_DST   = 3'd4;
  localparam logic [2:0] S_DWAIT = 3'd5;
  localparam logic [2:0] S_BLEND = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [1:0] sel_q, sel_d;
  logic       axis_q, axis_d, idx_q, idx_d;

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_OUT;
  assign last_o      = ({1'b0, idx_q} + 2'd1) == stat_i.res_cnt;

  always_comb begin
    state_d         = state_q;
    sel_d           = sel_q;
    axis_d          = axis_q;
    idx_d           = idx_q;
    cmd_o           = '0;
    cmd_o.sq_sel    = sel_q;
    cmd_o.axis      = axis_q;
    cmd_o.out_idx   = idx_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          sel_d   = SQ_SX;
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_en = 1'b1;
        sel_d       = sel_q + 2'd1;
        if (sel_q == SQ_DY) state_d = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        axis_d     = 1'b0;
        idx_d      = 1'b0;
        if (stat_i.need_div)            state_d = S_NUM;
        else if (stat_i.eval_cnt != '0) state_d = S_OUT;
        else                            state_d = S_IDLE;
      end
      S_NUM: begin
        cmd_o.num_en = 1'b1;
        state_d      = S_DST;
      end
      S_DST: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat_i.div_done) state_d = S_BLEND;
      end
      S_BLEND: begin
        cmd_o.blend_en = 1'b1;
        axis_d         = 1'b1;
        state_d        = axis_q ? S_OUT : S_NUM;
      end
      S_OUT: begin
        if (out_ready_i) begin
          idx_d   = 1'b1;
          state_d = last_o ? S_IDLE : S_OUT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sel_q   <= '0;
      axis_q  <= 1'b0;
      idx_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      axis_q  <= axis_d;
      idx_q   <= idx_d;
    end
  end

  `TCS_ASSERT_NEXT(a_accept_starts_sq, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_SQ)
  `TCS_ASSERT(a_out_has_result, clk_i, rst_ni, out_valid_o |-> stat_i.res_cnt != 2'd0)
  `TCS_ASSERT_NEXT(a_div_restarts, clk_i, rst_ni, state_q == S_DST, !stat_i.div_done)
  `TCS_ASSERT(a_second_is_last, clk_i, rst_ni, (out_valid_o && idx_q) |-> last_o)

endmodule
